>>> sv/prp_pkg.sv
// Package for the pressure relief policy block: result codes, register
// indexes and the packed layouts of the stream items.
// No dependencies.
package prp_pkg;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_DISABLED  = 3'd0,
        ACT_NONE      = 3'd1,
        ACT_OBSERVE   = 3'd2,
        ACT_UNLOAD    = 3'd3,
        ACT_DEFER     = 3'd4,
        ACT_SATURATED = 3'd5
    } action_t;

    // Policy state codes
    typedef enum logic [2:0] {
        ST_DISABLED  = 3'd0,
        ST_OBSERVING = 3'd1,
        ST_RELIEVING = 3'd2,
        ST_COOLDOWN  = 3'd3,
        ST_SATURATED = 3'd4,
        ST_RESTORE   = 3'd5
    } pstate_t;

    typedef enum logic [1:0] {
        LVL_LOW      = 2'd0,
        LVL_MEDIUM   = 2'd1,
        LVL_HIGH     = 2'd2,
        LVL_CRITICAL = 2'd3
    } level_t;

    typedef enum logic [3:0] {
        RSN_DISABLED   = 4'd0,
        RSN_HINT_OFF   = 4'd1,
        RSN_LOW        = 4'd2,
        RSN_FULL10     = 4'd3,
        RSN_SOME10_HI  = 4'd4,
        RSN_SOME60     = 4'd5,
        RSN_SOME10     = 4'd6,
        RSN_GROWTH     = 4'd7,
        RSN_NO_WEIGHTS = 4'd8,
        RSN_CAP        = 4'd9,
        RSN_COOLDOWN   = 4'd10
    } reason_t;

    // Policy modes (the remaining code behaves as disabled)
    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_THRESHOLD = 2'd1;
    localparam logic [1:0] MODE_HINT      = 2'd2;

    // Item commands
    localparam logic CMD_DECIDE = 1'b0;
    localparam logic CMD_UNLOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_AVG10_LIM  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOME_AVG10_LIM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOME_AVG60_LIM  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_GROWTH    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOAD_FRACTION = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TIME   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE       = 8'd7;
    localparam int CFG_DATA_W = 64;

    // Lower bound of the severe some avg10 threshold, hundredths percent
    localparam logic [16:0] HI10_FLOOR = 17'd500;

    localparam int IN_W  = 256;
    localparam int OUT_W = 64;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [47:0] now_time;
        logic        hint_active;
        logic        busy_req;
        logic [46:0] freed_size;
        logic [46:0] loaded_size;
        logic [13:0] full10_avg;
        logic        full_valid;
        logic [63:0] some_stall_us;
        logic [13:0] some60_avg;
        logic [13:0] some10_avg;
        logic        some_valid;
    } in_item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [47:0] target_size;
        reason_t     reason_code;
        level_t      pressure_level;
        pstate_t     policy_state;
        action_t     action;
    } out_item_t;

endpackage

>>> sv/pressure_relief_policy_top.sv
// Top level of the pressure relief policy block: grading, budget and
// cooldown rules between an input register and a result register.
// Depends on prp_pkg.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tdata decide sample, s_tuser command
//  m_      | out       | m_tvalid / m_tready  | m_tdata action .. target_size
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while m_ is not stalled. An accepted item sits in the input
// register; the result register then loads the result of a decide item, which
// is offered on m_. A record item updates the unload time and leaves a bubble.
// Both registers advance whenever the result register is empty or taken, so a
// stall on m_tready holds both and drops s_tready in the same cycle.
// aresetn is synchronous, active low; it clears valid bits, configuration
// registers and sample history. cfg_ready is always high.
module pressure_relief_policy_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // some_valid, some10_avg, some60_avg, some_stall_us, full_valid, full10_avg,
    // loaded_size, freed_size, busy_req, hint_active, now_time, zeros
    input  logic [prp_pkg::IN_W-1:0]           s_tdata,
    // command
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // action, policy_state, pressure_level, reason_code, target_size, zeros
    output logic [prp_pkg::OUT_W-1:0]          m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import prp_pkg::*;

    // Configuration registers
    logic [1:0]  mode_reg;
    logic [13:0] full10_lim_reg;
    logic [13:0] some10_lim_reg;
    logic [13:0] some60_lim_reg;
    logic [63:0] growth_lim_reg;
    logic [16:0] fraction_reg;
    logic [31:0] cooldown_reg;
    logic [47:0] step_reg;

    // History
    logic        prev_valid_reg;
    logic        prev_some_valid_reg;
    logic [63:0] prev_some_total_reg;
    logic        unload_seen_reg;
    logic [47:0] last_unload_reg;

    // Input and result registers
    logic        adv;
    logic        s1_valid_reg, out_valid_reg;
    in_item_t    s1_item_reg;
    logic        s1_cmd_reg;
    out_item_t   out_reg;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_DISABLED;
            full10_lim_reg <= '0;
            some10_lim_reg <= '0;
            some60_lim_reg <= '0;
            growth_lim_reg <= '0;
            fraction_reg   <= '0;
            cooldown_reg   <= '0;
            step_reg       <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POLICY_MODE:     mode_reg       <= cfg_data[1:0];
                REG_FULL_AVG10_LIM:  full10_lim_reg <= cfg_data[13:0];
                REG_SOME_AVG10_LIM:  some10_lim_reg <= cfg_data[13:0];
                REG_SOME_AVG60_LIM:  some60_lim_reg <= cfg_data[13:0];
                REG_STALL_GROWTH:    growth_lim_reg <= cfg_data;
                REG_UNLOAD_FRACTION: fraction_reg   <= cfg_data[16:0];
                REG_COOLDOWN_TIME:   cooldown_reg   <= cfg_data[31:0];
                REG_STEP_SIZE:       step_reg       <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= in_item_t'(s_tdata);
            s1_cmd_reg  <= s_tuser;
        end
    end

    // Grading, budget, cooldown and target rules on the registered item
    logic        s1_disabled, s1_hint_off, s1_growth;
    logic [16:0] hi10_prod, hi10;
    logic [64:0] growth_diff;
    logic [48:0] time_diff;
    logic [47:0] s1_total;
    logic        s1_frac_full;
    logic [15:0] s1_frac;
    logic [63:0] budget_prod;
    logic [47:0] max_unl;
    logic [47:0] avail;
    logic [48:0] tgt_raw;
    logic        no_wt, cool;
    out_item_t   res;

    always_comb begin
        s1_disabled = (mode_reg != MODE_THRESHOLD) && (mode_reg != MODE_HINT);
        s1_hint_off = (mode_reg == MODE_HINT) && !s1_item_reg.hint_active;

        growth_diff = {1'b0, s1_item_reg.some_stall_us} - {1'b0, prev_some_total_reg};
        s1_growth   = prev_valid_reg && prev_some_valid_reg && s1_item_reg.some_valid
                      && !growth_diff[64] && (growth_diff[63:0] != 64'd0)
                      && (growth_diff[63:0] >= growth_lim_reg);

        hi10_prod = {1'b0, some10_lim_reg, 2'b00} + {3'b000, some10_lim_reg};
        hi10      = (hi10_prod < HI10_FLOOR) ? HI10_FLOOR : hi10_prod;

        s1_total     = {1'b0, s1_item_reg.loaded_size}
                       + {1'b0, s1_item_reg.freed_size};
        s1_frac_full = fraction_reg[16];
        s1_frac      = s1_frac_full ? 16'd0 : fraction_reg[15:0];

        // Budget: 48x16 product with Q0.16 truncation; a full share passes the total
        budget_prod = {16'd0, s1_total} * {48'd0, s1_frac};
        max_unl     = s1_frac_full ? s1_total : budget_prod[63:16];
        avail       = max_unl - {1'b0, s1_item_reg.freed_size};
        no_wt       = (s1_total == 48'd0) || (!s1_frac_full && s1_frac == 16'd0);

        // Signed elapsed time since the last unload
        time_diff = {1'b0, s1_item_reg.now_time} - {1'b0, last_unload_reg};
        cool      = unload_seen_reg
                    && ($signed(time_diff) < $signed({17'd0, cooldown_reg}));

        res                = '0;
        res.action         = ACT_OBSERVE;
        res.policy_state   = ST_OBSERVING;
        res.pressure_level = LVL_LOW;
        res.reason_code    = RSN_LOW;

        // Prioritized level grading
        if (s1_item_reg.full_valid && s1_item_reg.full10_avg > full10_lim_reg) begin
            res.pressure_level = LVL_CRITICAL;
            res.reason_code    = RSN_FULL10;
        end else if (s1_item_reg.some_valid && {3'b000, s1_item_reg.some10_avg} >= hi10) begin
            res.pressure_level = LVL_HIGH;
            res.reason_code    = RSN_SOME10_HI;
        end else if (s1_item_reg.some_valid && s1_item_reg.some60_avg >= some60_lim_reg) begin
            res.pressure_level = LVL_HIGH;
            res.reason_code    = RSN_SOME60;
        end else if (s1_item_reg.some_valid && s1_item_reg.some10_avg >= some10_lim_reg) begin
            res.pressure_level = LVL_MEDIUM;
            res.reason_code    = RSN_SOME10;
        end else if (s1_growth) begin
            res.pressure_level = LVL_MEDIUM;
            res.reason_code    = RSN_GROWTH;
        end

        // Step, doubled when critical
        tgt_raw = (res.pressure_level == LVL_CRITICAL) ? {step_reg, 1'b0} : {1'b0, step_reg};

        // Mode overrides, then budget rules above low level
        if (s1_disabled) begin
            res.action         = ACT_DISABLED;
            res.policy_state   = ST_DISABLED;
            res.pressure_level = LVL_LOW;
            res.reason_code    = RSN_DISABLED;
        end else if (s1_hint_off) begin
            res.pressure_level = LVL_LOW;
            res.reason_code    = RSN_HINT_OFF;
        end else if (res.pressure_level != LVL_LOW) begin
            if (no_wt) begin
                res.action       = ACT_NONE;
                res.policy_state = ST_OBSERVING;
                res.reason_code  = RSN_NO_WEIGHTS;
            end else if ({1'b0, s1_item_reg.freed_size} >= max_unl) begin
                res.action       = ACT_SATURATED;
                res.policy_state = ST_SATURATED;
                res.reason_code  = RSN_CAP;
            end else if (cool) begin
                res.action       = ACT_OBSERVE;
                res.policy_state = ST_COOLDOWN;
                res.reason_code  = RSN_COOLDOWN;
            end else begin
                res.target_size  = (tgt_raw > {1'b0, avail}) ? avail : tgt_raw[47:0];
                res.action       = s1_item_reg.busy_req ? ACT_DEFER : ACT_UNLOAD;
                res.policy_state = s1_item_reg.busy_req ? ST_RESTORE : ST_RELIEVING;
            end
        end
    end

    // History updates as items leave the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg      <= 1'b0;
            prev_some_valid_reg <= 1'b0;
            prev_some_total_reg <= '0;
            unload_seen_reg     <= 1'b0;
            last_unload_reg     <= '0;
        end else if (adv && s1_valid_reg) begin
            if (s1_cmd_reg == CMD_UNLOAD) begin
                unload_seen_reg <= 1'b1;
                last_unload_reg <= s1_item_reg.now_time;
            end else if (!s1_disabled) begin
                prev_valid_reg      <= 1'b1;
                prev_some_valid_reg <= s1_item_reg.some_valid;
                prev_some_total_reg <= s1_item_reg.some_stall_us;
            end
        end
    end

    // Result valid; record items leave a bubble
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s1_valid_reg && (s1_cmd_reg == CMD_DECIDE);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= res;
        end
    end

endmodule
